// File: src/pqs_pkg.sv
// Shared types and constants for the three-level priority index queue.
// No dependencies; pqs_datapath, pqs_controller and the top level import this package.
package pqs_pkg;

    localparam int IDX_W  = 12;
    localparam int PRIO_W = 2;
    localparam int STAT_W = 3;
    localparam int ACT_W  = 3;
    localparam int CNT_W  = 13;

    localparam logic [CNT_W-1:0] ITEM_COUNT_RESET = 13'd4096;

    typedef enum logic [ACT_W-1:0] {
        ACT_PEEK  = 3'd0,
        ACT_POP   = 3'd1,
        ACT_PUSH  = 3'd2,
        ACT_SETP  = 3'd3,
        ACT_GETP  = 3'd4,
        ACT_CLEAR = 3'd5
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD        = 3'd1,
        ST_ALREADY    = 3'd2,
        ST_NOT_QUEUED = 3'd3,
        ST_EMPTY      = 3'd4
    } status_t;

    localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_NORMAL = 2'd1;
    localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd2;

    typedef enum logic [1:0] {
        FS_ZERO = 2'd0,
        FS_HEAD = 2'd1,
        FS_X    = 2'd2
    } front_src_t;

    typedef struct packed {
        logic       accept;
        logic       x_from_head;
        logic       sweep_init;
        logic       sweep_clear;
        logic       clr_lists;
        logic       take_attr;
        logic       link_rd;
        logic       unlink;
        logic       unlink_pop;
        logic       append1;
        logic       append2;
        logic       res_load;
        status_t    res_status;
        front_src_t res_front;
        logic       res_prio;
    } cmd_t;

    typedef struct packed {
        logic all_empty;
        logic ix_valid;
        logic np_ok;
        logic queued;
        logic same_prio;
        logic sweep_last;
    } stat_t;

endpackage

// File: src/pqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// File: src/pqs_datapath.sv
// Datapath: list head/tail registers, attribute and link memories, sweep
// counter and result registers. Depends on pqs_pkg and pqs_ram.
module pqs_datapath #(
    parameter int MAX_ITEMS = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pqs_pkg::CNT_W-1:0]  cfg_data,
    input  logic [pqs_pkg::IDX_W-1:0]  item_index,
    input  logic [pqs_pkg::PRIO_W-1:0] new_priority,
    input  pqs_pkg::cmd_t              cmd,
    output pqs_pkg::stat_t             stat,
    output logic [pqs_pkg::STAT_W-1:0] status,
    output logic [pqs_pkg::IDX_W-1:0]  front_index,
    output logic [pqs_pkg::PRIO_W-1:0] priority_out
);
    import pqs_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ITEMS - 1);

    logic [CNT_W-1:0]  item_count_reg;
    logic [IDX_W-1:0]  head_reg [3];
    logic [IDX_W-1:0]  tail_reg [3];
    logic [2:0]        ne_reg;
    logic [IDX_W-1:0]  x_reg;
    logic [PRIO_W-1:0] p_reg;
    logic [PRIO_W-1:0] np_reg;
    logic [AW-1:0]     cnt_reg;
    logic [STAT_W-1:0] status_reg;
    logic [IDX_W-1:0]  front_reg;
    logic [PRIO_W-1:0] prio_reg;

    logic [1:0]        hp;
    logic [IDX_W-1:0]  head_hp;
    logic [PRIO_W-1:0] prio_rd;
    logic              mark_rd;
    logic [IDX_W-1:0]  nxt_rd;
    logic [IDX_W-1:0]  prv_rd;
    logic              at_head;
    logic              at_tail;

    logic              prio_we;
    logic [AW-1:0]     prio_wa;
    logic [PRIO_W-1:0] prio_wd;
    logic              mark_we;
    logic [AW-1:0]     mark_wa;
    logic              mark_wd;
    logic              nl_we;
    logic [AW-1:0]     nl_wa;
    logic [IDX_W-1:0]  nl_wd;
    logic              pl_we;
    logic [AW-1:0]     pl_wa;
    logic [IDX_W-1:0]  pl_wd;

    assign hp      = ne_reg[PRIO_HIGH] ? PRIO_HIGH :
                     (ne_reg[PRIO_NORMAL] ? PRIO_NORMAL : PRIO_LOW);
    assign head_hp = head_reg[hp];
    assign at_head = (head_reg[p_reg] == x_reg);
    assign at_tail = (tail_reg[p_reg] == x_reg);

    assign stat.all_empty  = ~|ne_reg;
    assign stat.ix_valid   = ({1'b0, item_index} < item_count_reg)
                             && (17'(item_index) < 17'(MAX_ITEMS));
    assign stat.np_ok      = (new_priority <= PRIO_HIGH);
    assign stat.queued     = mark_rd;
    assign stat.same_prio  = (prio_rd == np_reg);
    assign stat.sweep_last = (cnt_reg == LAST_ADDR);

    // memory write ports
    always_comb
    begin
        prio_we = cmd.sweep_init | cmd.append1;
        prio_wa = cmd.sweep_init ? cnt_reg : AW'(x_reg);
        prio_wd = cmd.sweep_init ? PRIO_NORMAL : p_reg;

        mark_we = cmd.sweep_init | cmd.sweep_clear | cmd.append1
                  | (cmd.unlink & cmd.unlink_pop);
        mark_wa = (cmd.sweep_init | cmd.sweep_clear) ? cnt_reg : AW'(x_reg);
        mark_wd = cmd.append1;

        nl_we = 1'b0;
        nl_wa = AW'(x_reg);
        nl_wd = '0;
        pl_we = 1'b0;
        pl_wa = AW'(x_reg);
        pl_wd = '0;
        if (cmd.unlink)
        begin
            nl_we = ~at_head;
            nl_wa = AW'(prv_rd);
            nl_wd = nxt_rd;
            pl_we = ~at_tail;
            pl_wa = AW'(nxt_rd);
            pl_wd = prv_rd;
        end
        else if (cmd.append1)
        begin
            nl_we = ne_reg[p_reg];
            nl_wa = AW'(tail_reg[p_reg]);
            nl_wd = x_reg;
            pl_we = 1'b1;
            pl_wd = ne_reg[p_reg] ? tail_reg[p_reg] : '0;
        end
        else if (cmd.append2)
        begin
            nl_we = 1'b1;
        end
    end

    pqs_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_ITEMS)) u_prio_ram (
        .clk(clk), .we(prio_we), .wr_addr(prio_wa), .wr_data(prio_wd),
        .re(cmd.accept), .rd_addr(AW'(item_index)), .rd_data(prio_rd)
    );

    pqs_ram #(.WIDTH(1), .DEPTH(MAX_ITEMS)) u_mark_ram (
        .clk(clk), .we(mark_we), .wr_addr(mark_wa), .wr_data(mark_wd),
        .re(cmd.accept), .rd_addr(AW'(item_index)), .rd_data(mark_rd)
    );

    pqs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_next_ram (
        .clk(clk), .we(nl_we), .wr_addr(nl_wa), .wr_data(nl_wd),
        .re(cmd.link_rd), .rd_addr(AW'(x_reg)), .rd_data(nxt_rd)
    );

    pqs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_prev_ram (
        .clk(clk), .we(pl_we), .wr_addr(pl_wa), .wr_data(pl_wd),
        .re(cmd.link_rd), .rd_addr(AW'(x_reg)), .rd_data(prv_rd)
    );

    // list registers, sweep counter and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= ITEM_COUNT_RESET;
            ne_reg         <= '0;
            cnt_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                item_count_reg <= cfg_data;
            end
            if (cmd.sweep_init | cmd.sweep_clear)
            begin
                cnt_reg <= (cnt_reg == LAST_ADDR) ? '0 : cnt_reg + 1'b1;
            end
            if (cmd.clr_lists)
            begin
                ne_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    head_reg[i] <= '0;
                    tail_reg[i] <= '0;
                end
            end
            else if (cmd.unlink)
            begin
                if (at_head && at_tail)
                begin
                    ne_reg[p_reg]   <= 1'b0;
                    head_reg[p_reg] <= '0;
                    tail_reg[p_reg] <= '0;
                end
                else
                begin
                    if (at_head)
                    begin
                        head_reg[p_reg] <= nxt_rd;
                    end
                    if (at_tail)
                    begin
                        tail_reg[p_reg] <= prv_rd;
                    end
                end
            end
            else if (cmd.append1)
            begin
                if (!ne_reg[p_reg])
                begin
                    head_reg[p_reg] <= x_reg;
                    ne_reg[p_reg]   <= 1'b1;
                end
                tail_reg[p_reg] <= x_reg;
            end
        end
    end

    // working registers and results
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            np_reg <= new_priority;
            x_reg  <= cmd.x_from_head ? head_hp : item_index;
            p_reg  <= hp;
        end
        if (cmd.take_attr)
        begin
            p_reg <= prio_rd;
        end
        if (cmd.unlink && !cmd.unlink_pop)
        begin
            p_reg <= np_reg;
        end
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            prio_reg   <= cmd.res_prio ? prio_rd : '0;
            unique case (cmd.res_front)
                FS_HEAD: front_reg <= head_hp;
                FS_X:    front_reg <= x_reg;
                default: front_reg <= '0;
            endcase
        end
    end

    assign status       = status_reg;
    assign front_index  = front_reg;
    assign priority_out = prio_reg;
endmodule

// File: src/pqs_controller.sv
// Controller state machine: sequences memory sweeps, attribute reads,
// unlink and append steps. Depends on pqs_pkg.
module pqs_controller (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pqs_pkg::ACT_W-1:0] action,
    input  pqs_pkg::stat_t            stat,
    output pqs_pkg::cmd_t             cmd,
    output logic                      busy,
    output logic                      done
);
    import pqs_pkg::*;

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_ATTR   = 9'b000000100,
        S_LRD    = 9'b000001000,
        S_UNLINK = 9'b000010000,
        S_APP1   = 9'b000100000,
        S_APP2   = 9'b001000000,
        S_CLEAR  = 9'b010000000,
        S_RESP   = 9'b100000000
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    action_t act_reg;
    action_t act_in;

    assign act_in = action_t'(action);
    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_RESP);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_status = ST_OK;
        cmd.res_front  = FS_ZERO;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep_init = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept      = 1'b1;
                    cmd.x_from_head = (act_in == ACT_POP);
                    state_next      = S_RESP;
                    cmd.res_load    = 1'b1;
                    priority case (act_in)
                        ACT_PEEK, ACT_POP:
                        begin
                            if (stat.all_empty)
                            begin
                                cmd.res_status = ST_EMPTY;
                            end
                            else if (act_in == ACT_PEEK)
                            begin
                                cmd.res_front = FS_HEAD;
                            end
                            else
                            begin
                                cmd.res_load = 1'b0;
                                state_next   = S_LRD;
                            end
                        end
                        ACT_PUSH, ACT_GETP, ACT_SETP:
                        begin
                            if (!stat.ix_valid || (act_in == ACT_SETP && !stat.np_ok))
                            begin
                                cmd.res_status = ST_BAD;
                            end
                            else
                            begin
                                cmd.res_load = 1'b0;
                                state_next   = S_ATTR;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cmd.res_load  = 1'b0;
                            cmd.clr_lists = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            cmd.res_status = ST_BAD;
                        end
                    endcase
                end
            end
            S_ATTR:
            begin
                state_next   = S_RESP;
                cmd.res_load = 1'b1;
                priority case (act_reg)
                    ACT_PUSH:
                    begin
                        if (stat.queued)
                        begin
                            cmd.res_status = ST_ALREADY;
                        end
                        else
                        begin
                            cmd.res_load  = 1'b0;
                            cmd.take_attr = 1'b1;
                            state_next    = S_APP1;
                        end
                    end
                    ACT_SETP:
                    begin
                        if (!stat.queued)
                        begin
                            cmd.res_status = ST_NOT_QUEUED;
                        end
                        else if (!stat.same_prio)
                        begin
                            cmd.res_load  = 1'b0;
                            cmd.take_attr = 1'b1;
                            state_next    = S_LRD;
                        end
                    end
                    default:
                    begin
                        cmd.res_prio = 1'b1;
                    end
                endcase
            end
            S_LRD:
            begin
                cmd.link_rd = 1'b1;
                state_next  = S_UNLINK;
            end
            S_UNLINK:
            begin
                cmd.unlink = 1'b1;
                if (act_reg == ACT_POP)
                begin
                    cmd.unlink_pop = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_front  = FS_X;
                    state_next     = S_RESP;
                end
                else
                begin
                    state_next = S_APP1;
                end
            end
            S_APP1:
            begin
                cmd.append1 = 1'b1;
                state_next  = S_APP2;
            end
            S_APP2:
            begin
                cmd.append2  = 1'b1;
                cmd.res_load = 1'b1;
                state_next   = S_RESP;
            end
            S_CLEAR:
            begin
                cmd.sweep_clear = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            act_reg   <= ACT_PEEK;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.accept)
            begin
                act_reg <= act_in;
            end
        end
    end
endmodule

// File: src/three_level_priority_index_queue_top.sv
// Top level of the three-level priority index queue.
// Depends on pqs_pkg, pqs_controller and pqs_datapath.
//
// Keeps item indices in three FIFO lists (high, normal, low) linked through
// next/prev link memories. Issue a request by raising start while busy is
// low; the request is taken at that clock edge. Exactly one result follows
// per request: status, front_index and priority_out are valid for the single
// cycle in which done is high, and the receiver cannot stall them, so capture
// them then. Peek, errors and get priority answer from the request or the
// attribute read; pop reads the links and unlinks; push reads the attributes
// and appends; a priority move reads the attributes and the links, unlinks
// and appends. Clear sweeps the queued-mark memory one entry per cycle.
// After reset the block runs a clearing pass with busy high, setting every
// stored priority to normal and every queued mark to zero. Write item_count
// through cfg_we/cfg_data only while no request is outstanding.
module three_level_priority_index_queue_top #(
    parameter int MAX_ITEMS = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    output logic                       done,
    input  logic [pqs_pkg::ACT_W-1:0]  action,
    input  logic [pqs_pkg::IDX_W-1:0]  item_index,
    input  logic [pqs_pkg::PRIO_W-1:0] new_priority,
    output logic [pqs_pkg::STAT_W-1:0] status,
    output logic [pqs_pkg::IDX_W-1:0]  front_index,
    output logic [pqs_pkg::PRIO_W-1:0] priority_out,
    input  logic                       cfg_we,
    input  logic [pqs_pkg::CNT_W-1:0]  cfg_data
);
    import pqs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequence each request
    pqs_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // hold lists, memories and results
    pqs_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .item_index   (item_index),
        .new_priority (new_priority),
        .cmd          (cmd),
        .stat         (stat),
        .status       (status),
        .front_index  (front_index),
        .priority_out (priority_out)
    );
endmodule
